// ===== hw/rtl/cfpk_pkg.sv =====
// ============================================================================
// cfpk_pkg
// Shared types, constants and byte-level functions of the chunked frame
// packetizer: the word descriptor passed from the front end to the back end,
// header layout and the reflected CRC-32 step.
// ============================================================================
package cfpk_pkg;

    localparam int FRAME_W = 24;
    localparam int CHUNK_W = 13;
    localparam int SEQ_W   = 16;
    localparam int GEOM_W  = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int SLOT_W  = 5;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH       = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT      = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHUNK_PAYLOAD_MAX = 2'd2;

    localparam logic [CHUNK_W-1:0] CHUNK_MAX_RESET = 13'd4096;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    localparam logic [7:0] HDR_MAGIC0  = 8'h43;
    localparam logic [7:0] HDR_MAGIC1  = 8'h41;
    localparam logic [7:0] HDR_MAGIC2  = 8'h4D;
    localparam logic [7:0] HDR_MAGIC3  = 8'h31;
    localparam logic [7:0] HDR_VERSION = 8'h01;

    // Output slots of one descriptor: header bytes, the data byte, CRC bytes.
    localparam logic [SLOT_W-1:0] SLOT_HDR_FIRST = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_CRC_FROM  = 5'd4;
    localparam logic [SLOT_W-1:0] SLOT_DATA      = 5'd22;
    localparam logic [SLOT_W-1:0] SLOT_CRC0      = 5'd23;
    localparam logic [SLOT_W-1:0] SLOT_CRC3      = 5'd26;

    typedef struct packed {
        logic [7:0]         data;
        logic               hdr;
        logic               tail;
        logic               last;
        logic               flag_start;
        logic               flag_end;
        logic [SEQ_W-1:0]   seq;
        logic [FRAME_W-1:0] offset;
        logic [FRAME_W-1:0] total;
        logic [GEOM_W-1:0]  width;
        logic [GEOM_W-1:0]  height;
        logic [CHUNK_W-1:0] clen;
    } desc_t;

    function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] hdr_byte(logic [SLOT_W-1:0] idx, desc_t d);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = HDR_MAGIC0;
            5'd1:    b = HDR_MAGIC1;
            5'd2:    b = HDR_MAGIC2;
            5'd3:    b = HDR_MAGIC3;
            5'd4:    b = HDR_VERSION;
            5'd5:    b = {6'd0, d.flag_end, d.flag_start};
            5'd6:    b = d.seq[7:0];
            5'd7:    b = d.seq[15:8];
            5'd8:    b = d.offset[7:0];
            5'd9:    b = d.offset[15:8];
            5'd10:   b = d.offset[23:16];
            5'd12:   b = d.total[7:0];
            5'd13:   b = d.total[15:8];
            5'd14:   b = d.total[23:16];
            5'd16:   b = d.width[7:0];
            5'd17:   b = d.width[15:8];
            5'd18:   b = d.height[7:0];
            5'd19:   b = d.height[15:8];
            5'd20:   b = d.clen[7:0];
            5'd21:   b = {3'd0, d.clen[12:8]};
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/cfpk_front.sv =====
// ============================================================================
// cfpk_front
// Accepts frame bytes, tracks frame and chunk position, and turns every word
// into a descriptor that says whether a header precedes it and a CRC follows.
// ============================================================================
module cfpk_front #(
    parameter int MAX_CHUNK_BYTES = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cfpk_pkg::IDX_W-1:0]     cfg_index,
    input  logic [cfpk_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_frame_byte,
    input  logic [cfpk_pkg::FRAME_W-1:0]   s_frame_length,
    output logic                           push_valid,
    input  logic                           push_ready,
    output cfpk_pkg::desc_t                push_data
);

    localparam logic [cfpk_pkg::CHUNK_W-1:0] CAP_MAX = cfpk_pkg::CHUNK_W'(MAX_CHUNK_BYTES);

    logic [cfpk_pkg::GEOM_W-1:0]  width_reg;
    logic [cfpk_pkg::GEOM_W-1:0]  height_reg;
    logic [cfpk_pkg::CHUNK_W-1:0] cmax_reg;
    logic [cfpk_pkg::SEQ_W-1:0]   seq_reg;
    logic [cfpk_pkg::FRAME_W-1:0] offset_reg;
    logic [cfpk_pkg::FRAME_W-1:0] total_reg;
    logic [cfpk_pkg::CHUNK_W-1:0] clen_reg;
    logic [cfpk_pkg::CHUNK_W-1:0] pos_reg;

    logic                           accept;
    logic                           new_frame;
    logic                           chunk_start;
    logic [cfpk_pkg::FRAME_W-1:0]   len_in;
    logic [cfpk_pkg::FRAME_W-1:0]   total_cur;
    logic [cfpk_pkg::SEQ_W-1:0]     seq_cur;
    logic [cfpk_pkg::CHUNK_W-1:0]   cap;
    logic                           over;
    logic                           fits;
    logic [cfpk_pkg::FRAME_W-1:0]   remaining;
    logic [cfpk_pkg::CHUNK_W-1:0]   clen_new;
    logic [cfpk_pkg::CHUNK_W-1:0]   clen_cur;
    logic [cfpk_pkg::CHUNK_W-1:0]   pos_inc;
    logic [cfpk_pkg::FRAME_W-1:0]   off_inc;
    logic                           tail;
    logic                           last;

    assign accept     = s_valid && push_ready;
    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        new_frame   = (offset_reg == '0) && (pos_reg == '0);
        chunk_start = (pos_reg == '0);
        len_in      = (s_frame_length == '0) ? cfpk_pkg::FRAME_W'(1) : s_frame_length;
        total_cur   = new_frame ? len_in : total_reg;
        seq_cur     = new_frame ? seq_reg + 1'b1 : seq_reg;

        if (cmax_reg == '0) begin
            cap = cfpk_pkg::CHUNK_W'(1);
        end else if (cmax_reg > CAP_MAX) begin
            cap = CAP_MAX;
        end else begin
            cap = cmax_reg;
        end

        // When the offset has reached the total, the chunk carries one byte
        // and is also the frame's last chunk.
        over      = (total_cur <= offset_reg);
        remaining = total_cur - offset_reg;
        fits      = over || (remaining <= {{(cfpk_pkg::FRAME_W-cfpk_pkg::CHUNK_W){1'b0}}, cap});
        if (over) begin
            clen_new = cfpk_pkg::CHUNK_W'(1);
        end else if (fits) begin
            clen_new = remaining[cfpk_pkg::CHUNK_W-1:0];
        end else begin
            clen_new = cap;
        end
        clen_cur = chunk_start ? clen_new : clen_reg;

        pos_inc = pos_reg + 1'b1;
        off_inc = offset_reg + 1'b1;
        tail    = (pos_inc >= clen_cur);
        last    = (off_inc >= total_cur);

        push_data.data       = s_frame_byte;
        push_data.hdr        = chunk_start;
        push_data.tail       = tail;
        push_data.last       = last;
        push_data.flag_start = (offset_reg == '0);
        push_data.flag_end   = fits;
        push_data.seq        = seq_cur;
        push_data.offset     = offset_reg;
        push_data.total      = total_cur;
        push_data.width      = width_reg;
        push_data.height     = height_reg;
        push_data.clen       = clen_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
            cmax_reg   <= cfpk_pkg::CHUNK_MAX_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cfpk_pkg::REG_IMAGE_WIDTH:       width_reg  <= cfg_wdata;
                cfpk_pkg::REG_IMAGE_HEIGHT:      height_reg <= cfg_wdata;
                cfpk_pkg::REG_CHUNK_PAYLOAD_MAX: cmax_reg   <= cfg_wdata[cfpk_pkg::CHUNK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg    <= '0;
            offset_reg <= '0;
            total_reg  <= '0;
            clen_reg   <= '0;
            pos_reg    <= '0;
        end else if (accept) begin
            seq_reg   <= seq_cur;
            total_reg <= total_cur;
            if (chunk_start) begin
                clen_reg <= clen_new;
            end
            if (tail) begin
                pos_reg    <= '0;
                offset_reg <= last ? '0 : off_inc;
            end else begin
                pos_reg    <= pos_inc;
                offset_reg <= off_inc;
            end
        end
    end

endmodule

// ===== hw/rtl/cfpk_queue.sv =====
// ============================================================================
// cfpk_queue
// Two-entry descriptor queue between the front end and the back end, so that
// either side can stall without holding up the other.
// ============================================================================
module cfpk_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  cfpk_pkg::desc_t  push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output cfpk_pkg::desc_t  pop_data
);

    cfpk_pkg::desc_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/cfpk_back.sv =====
// ============================================================================
// cfpk_back
// Output sequencer: walks each descriptor through its header, data and CRC
// slots, one byte per cycle unless stalled, and keeps the running CRC-32.
// ============================================================================
module cfpk_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  cfpk_pkg::desc_t  pop_data,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_packet_byte,
    output logic             m_packet_end,
    output logic             m_frame_end
);

    logic                        busy_reg;
    logic [cfpk_pkg::SLOT_W-1:0] slot_reg;
    logic [31:0]                 crc_reg;
    logic                        m_valid_reg;
    logic [7:0]                  byte_reg;
    logic                        pend_reg;
    logic                        fend_reg;

    logic                        emit;
    logic                        at_end;
    logic [cfpk_pkg::SLOT_W-1:0] slot;
    logic [cfpk_pkg::SLOT_W-1:0] end_slot;
    logic [cfpk_pkg::SLOT_W-1:0] crc_sel;
    logic [31:0]                 fin;
    logic [7:0]                  byte_cur;

    assign emit = pop_valid && (!m_valid_reg || m_ready);

    always_comb begin
        if (busy_reg) begin
            slot = slot_reg;
        end else if (pop_data.hdr) begin
            slot = cfpk_pkg::SLOT_HDR_FIRST;
        end else begin
            slot = cfpk_pkg::SLOT_DATA;
        end
        end_slot  = pop_data.tail ? cfpk_pkg::SLOT_CRC3 : cfpk_pkg::SLOT_DATA;
        at_end    = (slot == end_slot);
        pop_ready = emit && at_end;

        fin     = crc_reg ^ cfpk_pkg::CRC_ALL_ONES;
        crc_sel = slot - cfpk_pkg::SLOT_CRC0;
        if (slot < cfpk_pkg::SLOT_DATA) begin
            byte_cur = cfpk_pkg::hdr_byte(slot, pop_data);
        end else if (slot == cfpk_pkg::SLOT_DATA) begin
            byte_cur = pop_data.data;
        end else begin
            case (crc_sel[1:0])
                2'd0:    byte_cur = fin[7:0];
                2'd1:    byte_cur = fin[15:8];
                2'd2:    byte_cur = fin[23:16];
                default: byte_cur = fin[31:24];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            slot_reg    <= '0;
            crc_reg     <= cfpk_pkg::CRC_ALL_ONES;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
                busy_reg    <= !at_end;
                slot_reg    <= slot + 1'b1;
                // The magic bytes stay out of the CRC; it restarts with each header.
                if (slot == cfpk_pkg::SLOT_HDR_FIRST) begin
                    crc_reg <= cfpk_pkg::CRC_ALL_ONES;
                end else if (slot >= cfpk_pkg::SLOT_CRC_FROM && slot <= cfpk_pkg::SLOT_DATA) begin
                    crc_reg <= cfpk_pkg::crc32_byte(crc_reg, byte_cur);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= byte_cur;
            pend_reg <= (slot == cfpk_pkg::SLOT_CRC3);
            fend_reg <= (slot == cfpk_pkg::SLOT_CRC3) && pop_data.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_packet_byte = byte_reg;
    assign m_packet_end  = pend_reg;
    assign m_frame_end   = fend_reg;

endmodule

// ===== hw/rtl/chunked_frame_packetizer_crc32.sv =====
// ============================================================================
// chunked_frame_packetizer_crc32
// Cuts a stream of frame bytes into packets with a 22-byte header and a
// trailing CRC-32.
// ============================================================================
// Each input word is one frame byte; the frame length is taken from the first
// byte of every frame. Sustained rate is one input word per cycle while a
// chunk's payload flows and the output is ready. A word that opens a chunk
// also carries the 22 header bytes, and a word that closes a chunk adds the
// four CRC bytes, so input stalls while those go out once the two-entry
// descriptor queue is full. The rate is set by the back end, which sends one
// packet byte per cycle and advances the CRC by one byte per cycle while the
// output is ready. From input to first output byte, a word passes through the
// descriptor queue and then the output register. No clearing pass follows
// reset. Configuration writes take effect at once and should be made only while the block is idle.
module chunked_frame_packetizer_crc32 #(
    parameter int MAX_CHUNK_BYTES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cfpk_pkg::IDX_W-1:0]    cfg_index,
    input  logic [cfpk_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_frame_byte,
    input  logic [cfpk_pkg::FRAME_W-1:0]  s_frame_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_packet_byte,
    output logic                          m_packet_end,
    output logic                          m_frame_end
);

    logic            push_valid;
    logic            push_ready;
    cfpk_pkg::desc_t push_data;
    logic            q_valid;
    logic            q_ready;
    cfpk_pkg::desc_t q_data;

    cfpk_front #(
        .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_byte   (s_frame_byte),
        .s_frame_length (s_frame_length),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    cfpk_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    cfpk_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (q_valid),
        .pop_ready     (q_ready),
        .pop_data      (q_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packet_byte (m_packet_byte),
        .m_packet_end  (m_packet_end),
        .m_frame_end   (m_frame_end)
    );

`ifndef SYNTHESIS
    // A frame only ends on the last CRC byte of a packet.
    a_frame_end_on_packet_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_packet_end)
        else $error("frame_end without packet_end");

    // An accepted word is waiting in the queue on the next cycle.
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_valid)
        else $error("accepted word missing from queue");

    // Retiring a descriptor always leaves its last byte in the output register.
    a_pop_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |=> m_valid)
        else $error("descriptor retired without output word");
`endif

endmodule

// ===== tb/chunked_frame_packetizer_crc32_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// chunked_frame_packetizer_crc32_checker
// Watches the configuration port and both streams of the packetizer. Every
// accepted frame byte is expanded into the packet bytes that it must produce:
// its payload byte, after the header if it opens a chunk, before the CRC if
// it closes one. Every packet byte that leaves is compared with the oldest.
// ============================================================================
module chunked_frame_packetizer_crc32_checker #(
    parameter int MAX_CHUNK_BYTES = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cfpk_pkg::IDX_W-1:0]    cfg_index,
    input  logic [cfpk_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [7:0]                    s_frame_byte,
    input  logic [cfpk_pkg::FRAME_W-1:0]  s_frame_length,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [7:0]                    m_packet_byte,
    input  logic                          m_packet_end,
    input  logic                          m_frame_end,
    output int                            mismatch_count,
    output int                            bytes_outstanding
);

    typedef struct packed {
        logic [7:0] data;
        logic       packet_end;
        logic       frame_end;
    } packet_byte_t;

    packet_byte_t expected_bytes[$];

    logic [cfpk_pkg::GEOM_W-1:0]  image_width;
    logic [cfpk_pkg::GEOM_W-1:0]  image_height;
    logic [cfpk_pkg::CHUNK_W-1:0] payload_limit;
    logic [cfpk_pkg::SEQ_W-1:0]   frame_seq;
    logic [cfpk_pkg::FRAME_W-1:0] frame_offset;
    logic [cfpk_pkg::FRAME_W-1:0] frame_total;
    logic [cfpk_pkg::CHUNK_W-1:0] chunk_len;
    logic [cfpk_pkg::CHUNK_W-1:0] chunk_pos;
    logic [31:0]                  crc_acc;

    // Reflected CRC-32, one message bit at a time, least significant bit first.
    function automatic logic [31:0] fold_crc_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[31:1]} ^ (fb ? cfpk_pkg::CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    task automatic push_expected(input logic [7:0] data, input logic pend, input logic fend);
        packet_byte_t w;
        w.data       = data;
        w.packet_end = pend;
        w.frame_end  = fend;
        expected_bytes.push_back(w);
    endtask

    task automatic predict_packet_bytes(input logic [7:0] data,
                                        input logic [cfpk_pkg::FRAME_W-1:0] len);
        logic [7:0]                   hdr [0:21];
        logic [cfpk_pkg::CHUNK_W-1:0] cap;
        logic [cfpk_pkg::FRAME_W-1:0] remaining;
        logic [31:0]                  fcs;
        logic                         closes_frame;
        logic                         start_flag;
        logic                         end_flag;

        if (frame_offset == '0 && chunk_pos == '0) begin
            frame_total = (len == '0) ? cfpk_pkg::FRAME_W'(1) : len;
            frame_seq   = frame_seq + 1'b1;
        end

        if (chunk_pos == '0) begin
            cap = payload_limit;
            if (cap == '0)
                cap = cfpk_pkg::CHUNK_W'(1);
            else if (cap > MAX_CHUNK_BYTES)
                cap = cfpk_pkg::CHUNK_W'(MAX_CHUNK_BYTES);
            remaining  = (frame_total > frame_offset) ? frame_total - frame_offset
                                                      : cfpk_pkg::FRAME_W'(1);
            chunk_len  = (remaining > cap) ? cap : remaining[cfpk_pkg::CHUNK_W-1:0];
            start_flag = (frame_offset == '0);
            end_flag   = (({1'b0, frame_offset} + chunk_len) >= frame_total);

            hdr[0]  = cfpk_pkg::HDR_MAGIC0;
            hdr[1]  = cfpk_pkg::HDR_MAGIC1;
            hdr[2]  = cfpk_pkg::HDR_MAGIC2;
            hdr[3]  = cfpk_pkg::HDR_MAGIC3;
            hdr[4]  = cfpk_pkg::HDR_VERSION;
            hdr[5]  = {6'd0, end_flag, start_flag};
            hdr[6]  = frame_seq[7:0];
            hdr[7]  = frame_seq[15:8];
            hdr[8]  = frame_offset[7:0];
            hdr[9]  = frame_offset[15:8];
            hdr[10] = frame_offset[23:16];
            hdr[11] = 8'd0;
            hdr[12] = frame_total[7:0];
            hdr[13] = frame_total[15:8];
            hdr[14] = frame_total[23:16];
            hdr[15] = 8'd0;
            hdr[16] = image_width[7:0];
            hdr[17] = image_width[15:8];
            hdr[18] = image_height[7:0];
            hdr[19] = image_height[15:8];
            hdr[20] = chunk_len[7:0];
            hdr[21] = {3'd0, chunk_len[12:8]};

            // The magic is sent but stays out of the CRC.
            crc_acc = cfpk_pkg::CRC_ALL_ONES;
            for (int i = 0; i < 22; i++) begin
                if (i >= 4)
                    crc_acc = fold_crc_byte(crc_acc, hdr[i]);
                push_expected(hdr[i], 1'b0, 1'b0);
            end
        end

        crc_acc = fold_crc_byte(crc_acc, data);
        push_expected(data, 1'b0, 1'b0);
        chunk_pos    = chunk_pos + 1'b1;
        frame_offset = frame_offset + 1'b1;

        if (chunk_pos >= chunk_len) begin
            fcs          = crc_acc ^ cfpk_pkg::CRC_ALL_ONES;
            closes_frame = (frame_offset >= frame_total);
            push_expected(fcs[7:0], 1'b0, 1'b0);
            push_expected(fcs[15:8], 1'b0, 1'b0);
            push_expected(fcs[23:16], 1'b0, 1'b0);
            push_expected(fcs[31:24], 1'b1, closes_frame);
            chunk_pos = '0;
            crc_acc   = cfpk_pkg::CRC_ALL_ONES;
            if (closes_frame)
                frame_offset = '0;
        end
    endtask

    task automatic check_packet_byte();
        packet_byte_t want;
        if (expected_bytes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected word, none expected: byte %02h packet_end %0b frame_end %0b",
                     $time, m_packet_byte, m_packet_end, m_frame_end);
        end else begin
            want = expected_bytes.pop_front();
            if (want.data !== m_packet_byte) begin
                mismatch_count++;
                $display("%0t: packet_byte expected %02h, got %02h",
                         $time, want.data, m_packet_byte);
            end
            if (want.packet_end !== m_packet_end) begin
                mismatch_count++;
                $display("%0t: packet_end expected %0b, got %0b",
                         $time, want.packet_end, m_packet_end);
            end
            if (want.frame_end !== m_frame_end) begin
                mismatch_count++;
                $display("%0t: frame_end expected %0b, got %0b",
                         $time, want.frame_end, m_frame_end);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            image_width    = '0;
            image_height   = '0;
            payload_limit  = cfpk_pkg::CHUNK_MAX_RESET;
            frame_seq      = '0;
            frame_offset   = '0;
            frame_total    = '0;
            chunk_len      = '0;
            chunk_pos      = '0;
            crc_acc        = cfpk_pkg::CRC_ALL_ONES;
            mismatch_count = 0;
            expected_bytes.delete();
        end else begin
            if (s_valid && s_ready)
                predict_packet_bytes(s_frame_byte, s_frame_length);
            // A write counts from the following edge on.
            if (cfg_wr_en) begin
                case (cfg_index)
                    cfpk_pkg::REG_IMAGE_WIDTH:
                        image_width = cfg_wdata[cfpk_pkg::GEOM_W-1:0];
                    cfpk_pkg::REG_IMAGE_HEIGHT:
                        image_height = cfg_wdata[cfpk_pkg::GEOM_W-1:0];
                    cfpk_pkg::REG_CHUNK_PAYLOAD_MAX:
                        payload_limit = cfg_wdata[cfpk_pkg::CHUNK_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready)
                check_packet_byte();
        end
        bytes_outstanding = expected_bytes.size();
    end

endmodule

// ===== tb/chunked_frame_packetizer_crc32_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// chunked_frame_packetizer_crc32_tb
// Drives frames of bytes into the packetizer under a range of geometry and
// payload-limit settings, with random gaps on the input and random back
// pressure on the output, and reports the verdict of the checker beside it.
// ============================================================================
module chunked_frame_packetizer_crc32_tb;

    localparam int MAX_CHUNK_BYTES = 4096;
    // Index with no register behind it; writes to it must change nothing.
    localparam logic [cfpk_pkg::IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                         aclk;
    logic                         aresetn;
    logic                         cfg_wr_en;
    logic [cfpk_pkg::IDX_W-1:0]   cfg_index;
    logic [cfpk_pkg::CFG_W-1:0]   cfg_wdata;
    logic                         s_valid;
    logic                         s_ready;
    logic [7:0]                   s_frame_byte;
    logic [cfpk_pkg::FRAME_W-1:0] s_frame_length;
    logic                         m_valid;
    logic                         m_ready;
    logic [7:0]                   m_packet_byte;
    logic                         m_packet_end;
    logic                         m_frame_end;

    int mismatch_count;
    int bytes_outstanding;
    int words_sent;
    bit sink_steady;
    bit source_steady;
    bit hold_request;

    chunked_frame_packetizer_crc32 #(
        .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_byte  (s_frame_byte),
        .s_frame_length(s_frame_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packet_byte (m_packet_byte),
        .m_packet_end  (m_packet_end),
        .m_frame_end   (m_frame_end)
    );

    chunked_frame_packetizer_crc32_checker #(
        .MAX_CHUNK_BYTES(MAX_CHUNK_BYTES)
    ) packet_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_byte     (s_frame_byte),
        .s_frame_length   (s_frame_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_packet_byte    (m_packet_byte),
        .m_packet_end     (m_packet_end),
        .m_frame_end      (m_frame_end),
        .mismatch_count   (mismatch_count),
        .bytes_outstanding(bytes_outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin : watchdog
        #20_000_000;
        $display("chunked_frame_packetizer_crc32: mismatch");
        $finish;
    end

    // Output side: mostly ready, short stalls now and then, a few long ones,
    // and one long hold-off when asked for.
    initial begin : packet_sink
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else if (sink_steady || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
                repeat (stall) @(negedge aclk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (source_steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom());
    endfunction

    function automatic logic [cfpk_pkg::GEOM_W-1:0] pick_geometry();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r < 4)
            return '1;
        return cfpk_pkg::GEOM_W'($urandom());
    endfunction

    function automatic logic [cfpk_pkg::CFG_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 15)
            return ($urandom_range(0, 1) == 0) ? 16'hFFFF
                                               : cfpk_pkg::CFG_W'($urandom_range(4097, 8191));
        if (r < 20)
            return cfpk_pkg::CFG_W'(MAX_CHUNK_BYTES);
        if (r < 30)
            return cfpk_pkg::CFG_W'($urandom_range(9, 64));
        return cfpk_pkg::CFG_W'($urandom_range(1, 8));
    endfunction

    function automatic logic [cfpk_pkg::FRAME_W-1:0] pick_frame_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 90)
            return cfpk_pkg::FRAME_W'($urandom_range(1, 24));
        return cfpk_pkg::FRAME_W'($urandom_range(25, 80));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input logic [7:0] data,
                             input logic [cfpk_pkg::FRAME_W-1:0] length);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_frame_byte   <= data;
        s_frame_length <= length;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    // Only the first byte's length field matters; the rest carry noise.
    task automatic send_frame(input logic [cfpk_pkg::FRAME_W-1:0] length, input int count);
        for (int i = 0; i < count; i++)
            send_word(pick_byte(), (i == 0) ? length : cfpk_pkg::FRAME_W'($urandom()));
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (bytes_outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_settings(input logic [cfpk_pkg::CFG_W-1:0] width,
                                 input logic [cfpk_pkg::CFG_W-1:0] height,
                                 input logic [cfpk_pkg::CFG_W-1:0] limit);
        cfg_wr_en <= 1'b1;
        cfg_index <= cfpk_pkg::REG_IMAGE_WIDTH;
        cfg_wdata <= width;
        @(negedge aclk);
        cfg_index <= cfpk_pkg::REG_IMAGE_HEIGHT;
        cfg_wdata <= height;
        @(negedge aclk);
        cfg_index <= cfpk_pkg::REG_CHUNK_PAYLOAD_MAX;
        cfg_wdata <= limit;
        @(negedge aclk);
        cfg_index <= REG_UNMAPPED;
        cfg_wdata <= cfpk_pkg::CFG_W'($urandom());
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : frame_source
        logic [cfpk_pkg::FRAME_W-1:0] len;
        int                           target;
        bit                           hold_done;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = cfpk_pkg::REG_IMAGE_WIDTH;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_frame_byte   = '0;
        s_frame_length = '0;
        sink_steady    = 1'b0;
        source_steady  = 1'b0;
        hold_request   = 1'b0;
        words_sent     = 0;
        hold_done      = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings, and a zero frame length that must act as one.
        send_frame(24'd0, 1);
        wait_for_drain();

        // A zero payload limit acts as one byte per packet.
        load_settings(16'hFFFF, 16'hFFFF, 16'd0);
        send_frame(24'd3, 3);
        wait_for_drain();

        // Limits above the maximum clamp to it.
        load_settings(16'h1234, 16'h00FF, 16'hFFFF);
        send_frame(24'd5, 5);
        wait_for_drain();

        load_settings(16'h0001, 16'h8000, 16'd4096);
        send_frame(24'd2, 2);
        wait_for_drain();

        load_settings(16'h0000, 16'h0000, 16'd3);
        send_frame(24'd7, 7);
        wait_for_drain();

        // The limit is taken when a chunk opens, so raising it in the middle of
        // a chunk must not stretch that chunk.
        load_settings(16'hBEEF, 16'h0102, 16'd2);
        send_word(pick_byte(), 24'd5);
        wait_for_drain();
        load_settings(16'h00A5, 16'h5A00, 16'd4);
        send_frame(cfpk_pkg::FRAME_W'($urandom()), 4);
        wait_for_drain();

        target = words_sent + 180;
        while (words_sent < target) begin
            sink_steady   = ($urandom_range(0, 4) == 0);
            source_steady = ($urandom_range(0, 4) == 0);
            load_settings(pick_geometry(), pick_geometry(), pick_limit());
            if (!hold_done && words_sent > target - 90) begin
                // The sink stops long enough for the block to fill up and
                // refuse input while frame bytes are still being offered.
                hold_done     = 1'b1;
                sink_steady   = 1'b0;
                source_steady = 1'b1;
                hold_request  = 1'b1;
                load_settings(pick_geometry(), pick_geometry(), 16'd3);
                send_frame(24'd40, 40);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    len = pick_frame_length();
                    send_frame(len, (len == '0) ? 1 : int'(len));
                end
            end
            wait_for_drain();
        end

        // A frame of the largest length; it is left open at the end.
        sink_steady   = 1'b0;
        source_steady = 1'b0;
        load_settings(pick_geometry(), pick_geometry(), 16'd5);
        send_frame(24'hFFFFFF, 12);
        wait_for_drain();
        repeat (30) @(negedge aclk);

        if (mismatch_count == 0 && bytes_outstanding == 0)
            $display("chunked_frame_packetizer_crc32: match");
        else
            $display("chunked_frame_packetizer_crc32: mismatch");
        $finish;
    end

endmodule
